// ===== sv/lps_pkg.sv =====
// Shared constants and types for the linear prime sieve.
`default_nettype none
package lps_pkg;

	parameter int unsigned VAL_W          = 15;
	parameter int unsigned CNT_OUT_W      = 13;
	parameter int unsigned PROD_W         = 2 * VAL_W;
	parameter int unsigned DIV_CNT_W      = $clog2(VAL_W);
	parameter int unsigned DEF_MAX_N      = 32768;
	parameter int unsigned DEF_MAX_PRIMES = 4096;

	parameter logic [VAL_W-1:0] LIMIT_RST = 15'd10000;
	parameter logic [VAL_W-1:0] FIRST_CAND = 15'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_READ,
		S_CHECK,
		S_FETCH,
		S_MUL,
		S_CMP,
		S_DIV,
		S_FINISH,
		S_EMIT
	} state_t;

endpackage
`default_nettype wire

// ===== sv/lps_req_if.sv =====
// Request channel: one step of the sieve.
`default_nettype none
interface lps_req_if;
	logic valid;
	logic ready;
	logic start_req;

	modport source (output valid, output start_req, input ready);
	modport sink (input valid, input start_req, output ready);
endinterface
`default_nettype wire

// ===== sv/lps_rsp_if.sv =====
// Result channel: outcome of one sieve step.
`default_nettype none
interface lps_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [lps_pkg::VAL_W-1:0]       candidate;
	logic                            is_prime;
	logic [lps_pkg::CNT_OUT_W-1:0]   prime_count;
	logic                            done_res;

	modport source (output valid, output candidate, output is_prime, output prime_count,
		output done_res, input ready);
	modport sink (input valid, input candidate, input is_prime, input prime_count,
		input done_res, output ready);
endinterface
`default_nettype wire

// ===== sv/lps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lps_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/linear_prime_sieve_unit.sv =====
// Linear prime sieve: sequencer, mark and prime stores, shared multiply and divide unit.
//
//   channel  | dir | handshake   | payload
//   ---------+-----+-------------+--------------------------------------------------
//   req      | in  | valid/ready | start_req
//   rsp      | out | valid/ready | candidate, is_prime, prime_count, done_res
//   cfg      | in  | cfg_we      | cfg_wdata (sieve limit)
//
// A finished or out-of-range step just emits. Else a step reads the candidate's mark, lists
// it if unmarked and the list has room, and per prime walked marks the product and divides
// (restoring remainder, one bit a cycle) until list end, product over limit or prime divides.
// A start request with a limit of two or more first sweeps the mark store from 0 up to the
// highest mark written since the last sweep, one entry a cycle; after reset that is all MAX_N entries.
// The block takes one request at a time; a result waits in the output register
// while the next request is taken.
`default_nettype none
module linear_prime_sieve_unit #(
	parameter int unsigned MAX_N      = lps_pkg::DEF_MAX_N,
	parameter int unsigned MAX_PRIMES = lps_pkg::DEF_MAX_PRIMES
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	lps_req_if.sink                        req,
	lps_rsp_if.source                      rsp,
	input  wire logic                      cfg_we,
	input  wire logic [lps_pkg::VAL_W-1:0] cfg_wdata
);

	localparam int unsigned VW   = lps_pkg::VAL_W;
	localparam int unsigned PW   = lps_pkg::PROD_W;
	localparam int unsigned OCW  = lps_pkg::CNT_OUT_W;
	localparam int unsigned DCW  = lps_pkg::DIV_CNT_W;
	localparam int unsigned AW   = $clog2(MAX_N);
	localparam int unsigned LAW  = $clog2(MAX_PRIMES);
	localparam int unsigned CNTW = $clog2(MAX_PRIMES + 1);

	lps_pkg::state_t state_q, state_d;

	logic [VW-1:0]   lim_q;
	logic [VW-1:0]   cur_q;
	logic [CNTW-1:0] cnt_q;
	logic            fin_q;
	logic [AW-1:0]   hwm_q;
	logic [AW-1:0]   clr_q;
	logic [CNTW-1:0] j_q;
	logic [VW-1:0]   p_q;
	logic [PW-1:0]   prod_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   dvd_q;
	logic [DCW-1:0]  dcnt_q;
	logic            prime_q;

	logic [VW-1:0]   res_cand_q;
	logic            res_prime_q;
	logic [OCW-1:0]  res_cnt_q;
	logic            res_done_q;

	logic            o_vld_q;
	logic [VW-1:0]   o_cand_q;
	logic            o_prime_q;
	logic [OCW-1:0]  o_cnt_q;
	logic            o_done_q;

	logic [VW-1:0]   eff_lim;
	logic            accept;
	logic            rsp_free;
	logic            lim_low;
	logic            cur_at_lim;
	logic            list_room;
	logic            prod_over;
	logic [VW:0]     trial;
	logic            trial_ge;
	logic [VW-1:0]   rem_nx;

	logic            mark_we;
	logic [AW-1:0]   mark_waddr;
	logic [0:0]      mark_wdata;
	logic [0:0]      mark_rdata;
	logic            list_we;
	logic [VW-1:0]   list_rdata;

	always_comb begin
		if (32'(lim_q) > MAX_N - 1) begin
			eff_lim = VW'(MAX_N - 1);
		end else begin
			eff_lim = lim_q;
		end
	end

	assign req.ready  = (state_q == lps_pkg::S_IDLE);
	assign accept     = req.valid && req.ready;
	assign rsp_free   = !o_vld_q || rsp.ready;
	assign lim_low    = (eff_lim < lps_pkg::FIRST_CAND);
	assign cur_at_lim = (cur_q >= eff_lim);
	assign list_room  = (cnt_q < CNTW'(MAX_PRIMES));
	assign prod_over  = (prod_q > PW'(eff_lim));

	assign trial    = {rem_q, dvd_q[VW-1]};
	assign trial_ge = (trial >= {1'b0, p_q});
	assign rem_nx   = trial_ge ? VW'(trial - {1'b0, p_q}) : trial[VW-1:0];

	lps_ram #(
		.WIDTH (1),
		.DEPTH (MAX_N)
	) u_marks (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.raddr (AW'(cur_q)),
		.rdata (mark_rdata)
	);

	lps_ram #(
		.WIDTH (VW),
		.DEPTH (MAX_PRIMES)
	) u_primes (
		.clk   (clk),
		.we    (list_we),
		.waddr (cnt_q[LAW-1:0]),
		.wdata (cur_q),
		.raddr (j_q[LAW-1:0]),
		.rdata (list_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lps_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mark_we    = 1'b0;
		mark_waddr = clr_q;
		mark_wdata = 1'b0;
		list_we    = 1'b0;
		case (state_q)
			lps_pkg::S_IDLE: begin
				if (accept) begin
					if (req.start_req) begin
						state_d = lim_low ? lps_pkg::S_EMIT : lps_pkg::S_CLEAR;
					end else if (fin_q || cur_at_lim) begin
						state_d = lps_pkg::S_EMIT;
					end else begin
						state_d = lps_pkg::S_READ;
					end
				end
			end
			lps_pkg::S_CLEAR: begin
				mark_we = 1'b1;
				if (clr_q == hwm_q) begin
					state_d = lps_pkg::S_READ;
				end
			end
			lps_pkg::S_READ: begin
				state_d = lps_pkg::S_CHECK;
			end
			lps_pkg::S_CHECK: begin
				list_we = !mark_rdata[0] && list_room;
				state_d = lps_pkg::S_FETCH;
			end
			lps_pkg::S_FETCH: begin
				state_d = (j_q >= cnt_q) ? lps_pkg::S_FINISH : lps_pkg::S_MUL;
			end
			lps_pkg::S_MUL: begin
				state_d = lps_pkg::S_CMP;
			end
			lps_pkg::S_CMP: begin
				if (prod_over) begin
					state_d = lps_pkg::S_FINISH;
				end else begin
					mark_we    = 1'b1;
					mark_waddr = AW'(prod_q);
					mark_wdata = 1'b1;
					state_d    = lps_pkg::S_DIV;
				end
			end
			lps_pkg::S_DIV: begin
				if (dcnt_q == '0) begin
					state_d = (rem_nx == '0) ? lps_pkg::S_FINISH : lps_pkg::S_FETCH;
				end
			end
			lps_pkg::S_FINISH: begin
				state_d = lps_pkg::S_EMIT;
			end
			lps_pkg::S_EMIT: begin
				if (rsp_free) begin
					state_d = lps_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lps_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q   <= lps_pkg::LIMIT_RST;
			cur_q   <= '0;
			cnt_q   <= '0;
			fin_q   <= 1'b1;
			hwm_q   <= AW'(MAX_N - 1);
			o_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				lim_q <= cfg_wdata;
			end
			if (state_q == lps_pkg::S_EMIT && rsp_free) begin
				o_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				o_vld_q <= 1'b0;
			end
			case (state_q)
				lps_pkg::S_IDLE: begin
					if (accept) begin
						if (req.start_req) begin
							cnt_q <= '0;
							cur_q <= '0;
							fin_q <= lim_low;
						end else if (!fin_q) begin
							if (cur_at_lim) begin
								fin_q <= 1'b1;
							end else begin
								cur_q <= cur_q + VW'(1);
							end
						end
					end
				end
				lps_pkg::S_CLEAR: begin
					if (clr_q == hwm_q) begin
						hwm_q <= '0;
						cur_q <= lps_pkg::FIRST_CAND;
					end
				end
				lps_pkg::S_CHECK: begin
					if (list_we) begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				lps_pkg::S_CMP: begin
					if (!prod_over && AW'(prod_q) > hwm_q) begin
						hwm_q <= AW'(prod_q);
					end
				end
				lps_pkg::S_FINISH: begin
					if (cur_q == eff_lim) begin
						fin_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lps_pkg::S_IDLE: begin
				clr_q       <= '0;
				res_cand_q  <= '0;
				res_prime_q <= 1'b0;
				res_done_q  <= 1'b1;
				res_cnt_q   <= req.start_req ? '0 : OCW'(cnt_q);
			end
			lps_pkg::S_CLEAR: begin
				clr_q <= clr_q + AW'(1);
			end
			lps_pkg::S_CHECK: begin
				prime_q <= !mark_rdata[0];
				j_q     <= '0;
			end
			lps_pkg::S_MUL: begin
				p_q    <= list_rdata;
				prod_q <= PW'(cur_q) * PW'(list_rdata);
			end
			lps_pkg::S_CMP: begin
				rem_q  <= '0;
				dvd_q  <= cur_q;
				dcnt_q <= DCW'(VW - 1);
			end
			lps_pkg::S_DIV: begin
				rem_q  <= rem_nx;
				dvd_q  <= {dvd_q[VW-2:0], 1'b0};
				dcnt_q <= dcnt_q - DCW'(1);
				if (dcnt_q == '0) begin
					j_q <= j_q + CNTW'(1);
				end
			end
			lps_pkg::S_FINISH: begin
				res_cand_q  <= cur_q;
				res_prime_q <= prime_q;
				res_cnt_q   <= OCW'(cnt_q);
				res_done_q  <= (cur_q == eff_lim);
			end
			lps_pkg::S_EMIT: begin
				if (rsp_free) begin
					o_cand_q  <= res_cand_q;
					o_prime_q <= res_prime_q;
					o_cnt_q   <= res_cnt_q;
					o_done_q  <= res_done_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid       = o_vld_q;
	assign rsp.candidate   = o_cand_q;
	assign rsp.is_prime    = o_prime_q;
	assign rsp.prime_count = o_cnt_q;
	assign rsp.done_res    = o_done_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request taken while a step is in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(MAX_PRIMES))
		else $error("prime count beyond list depth");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lps_pkg::S_DIV) |-> (p_q != '0))
		else $error("divide step with zero divisor");

	a_live_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.done_res) |-> (rsp.candidate >= lps_pkg::FIRST_CAND))
		else $error("live result with candidate below two");
`endif

endmodule
`default_nettype wire
